// ===== hw/rtl/qvu_pkg.sv =====
// ----------------------------------------------------------------------------
// qvu_pkg
// Shared types, widths and helpers for the tabular Q value update engine.
// ----------------------------------------------------------------------------
package qvu_pkg;

    localparam int NUM_STATES_DEF  = 1024;
    localparam int NUM_ACTIONS_DEF = 8;

    localparam int Q_W      = 32;
    localparam int STATE_W  = 10;
    localparam int ACTION_W = 3;
    localparam int REWARD_W = 16;
    localparam int RATE_W   = 16;
    localparam int FRAC_W   = 16;

    localparam int CUR_LSB = 0;
    localparam int ACT_LSB = CUR_LSB + STATE_W;
    localparam int NXT_LSB = ACT_LSB + ACTION_W;
    localparam int RWD_LSB = NXT_LSB + STATE_W;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = Q_W;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [RATE_W-1:0] RATE_RESET = 16'd58982;
    localparam logic [RATE_W:0]   ONE_FIX    = 17'h10000;
    localparam logic [Q_W-1:0]    Q_MAX      = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0]    Q_MIN      = 32'h8000_0000;

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_READ   = 1'b1
    } t_opcode;

    typedef enum logic {
        REG_LEARN_RATE = 1'b0,
        REG_DISCOUNT   = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_MUL1,
        ST_MUL2,
        ST_WB
    } t_state;

    typedef struct packed {
        logic ld_rd;
        logic ld_mul1;
        logic ld_mul2;
    } t_dp_ctl;

    // Reduce a narrow index modulo n by restoring subtraction of shifted n.
    function automatic logic [STATE_W-1:0] idx_reduce(
        input logic [STATE_W-1:0] v,
        input logic [16:0]        n
    );
        logic [STATE_W+16:0] r;
        logic [STATE_W+16:0] m;
        int                  k;
        r = {17'b0, v};
        for (k = STATE_W - 1; k >= 0; k--) begin
            m = {{STATE_W{1'b0}}, n} << k;
            if (r >= m) begin
                r = r - m;
            end
        end
        return r[STATE_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/tabular_q_value_update_top.sv =====
// ----------------------------------------------------------------------------
// tabular_q_value_update_top
// Sequence: a read item goes through row read and write back; an update item
// through row read, keep/target multiply, gain multiply and sum at write back.
// Throughput: one item in flight; write back waits while the output is held.
// Reset: a clearing pass zeroes the table one row a cycle, with s_axis_tready
// low; register writes are taken throughout.
// ----------------------------------------------------------------------------
module tabular_q_value_update_top
    import qvu_pkg::*;
#(
    parameter int NUM_STATES  = NUM_STATES_DEF,
    parameter int NUM_ACTIONS = NUM_ACTIONS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // cur_state[9:0], action[12:10], next_state[22:13], reward[38:23], pad[39]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // opcode[0]
    input  logic [0:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // q_value[31:0]
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int AW  = $clog2(NUM_STATES);
    localparam int ACW = $clog2(NUM_ACTIONS);

    logic [RATE_W-1:0]                r_learn_rate;
    logic [RATE_W-1:0]                r_discount;
    logic                             w_cfg_wr;

    logic                             w_in_fire;
    logic [AW-1:0]                    w_cur_addr;
    logic [AW-1:0]                    w_nxt_addr;
    logic [ACW-1:0]                   w_act;
    t_opcode                          r_op;
    logic [AW-1:0]                    r_cur_addr;
    logic [ACW-1:0]                   r_act;
    logic [REWARD_W-1:0]              r_reward;

    t_dp_ctl                          w_dp_ctl;
    logic                             w_wb_fire;
    logic                             w_mem_we;
    logic                             w_clearing;
    logic [AW-1:0]                    w_clr_addr;
    logic                             w_out_free;

    logic [NUM_ACTIONS-1:0][Q_W-1:0]  w_row_cur;
    logic [NUM_ACTIONS-1:0][Q_W-1:0]  w_row_nxt;
    logic [NUM_ACTIONS-1:0][Q_W-1:0]  w_row_new;
    logic [NUM_ACTIONS-1:0][Q_W-1:0]  w_wr_data;
    logic [AW-1:0]                    w_wr_addr;
    logic [Q_W-1:0]                   w_result;

    logic                             r_out_valid;
    logic [Q_W-1:0]                   r_out_data;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn_rate <= RATE_RESET;
            r_discount   <= RATE_RESET;
        end else if (w_cfg_wr) begin
            unique case (t_reg_idx'(paddr[2]))
                REG_LEARN_RATE: r_learn_rate <= pwdata[RATE_W-1:0];
                REG_DISCOUNT:   r_discount   <= pwdata[RATE_W-1:0];
                default:        r_learn_rate <= r_learn_rate;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[2]))
            REG_LEARN_RATE: prdata = APB_DW'(r_learn_rate);
            REG_DISCOUNT:   prdata = APB_DW'(r_discount);
            default:        prdata = '0;
        endcase
    end

    assign w_in_fire  = s_axis_tvalid & s_axis_tready;
    assign w_cur_addr = AW'(idx_reduce(s_axis_tdata[CUR_LSB +: STATE_W], 17'(NUM_STATES)));
    assign w_nxt_addr = AW'(idx_reduce(s_axis_tdata[NXT_LSB +: STATE_W], 17'(NUM_STATES)));
    assign w_act      = ACW'(idx_reduce(STATE_W'(s_axis_tdata[ACT_LSB +: ACTION_W]),
                                        17'(NUM_ACTIONS)));

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_op       <= t_opcode'(s_axis_tuser[0]);
            r_cur_addr <= w_cur_addr;
            r_act      <= w_act;
            r_reward   <= s_axis_tdata[RWD_LSB +: REWARD_W];
        end
    end

    assign w_out_free = !r_out_valid || m_axis_tready;

    qvu_ctrl #(
        .NUM_STATES (NUM_STATES),
        .AW         (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_op       (r_op),
        .i_out_free (w_out_free),
        .o_in_ready (s_axis_tready),
        .o_dp_ctl   (w_dp_ctl),
        .o_wb_fire  (w_wb_fire),
        .o_mem_we   (w_mem_we),
        .o_clearing (w_clearing),
        .o_clr_addr (w_clr_addr)
    );

    assign w_wr_addr = w_clearing ? w_clr_addr : r_cur_addr;
    assign w_wr_data = w_clearing ? '0 : w_row_new;

    qvu_mem #(
        .DEPTH (NUM_STATES),
        .AW    (AW),
        .WIDTH (NUM_ACTIONS * Q_W)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rd_en     (w_in_fire),
        .i_rd_addr_a (w_cur_addr),
        .i_rd_addr_b (w_nxt_addr),
        .o_rd_data_a (w_row_cur),
        .o_rd_data_b (w_row_nxt),
        .i_we        (w_mem_we),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data)
    );

    qvu_dp #(
        .NUM_ACTIONS (NUM_ACTIONS),
        .ACW         (ACW)
    ) u_dp (
        .i_clk        (i_clk),
        .i_ctl        (w_dp_ctl),
        .i_op         (r_op),
        .i_act        (r_act),
        .i_reward     (r_reward),
        .i_learn_rate (r_learn_rate),
        .i_discount   (r_discount),
        .i_row_cur    (w_row_cur),
        .i_row_nxt    (w_row_nxt),
        .o_result     (w_result),
        .o_row_new    (w_row_new)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_wb_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wb_fire) begin
            r_out_data <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> !s_axis_tready)
        else $error("input transfer taken while an item is in flight");

    a_result_from_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_wb_fire))
        else $error("result appeared without a write back");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> (!s_axis_tready && !m_axis_tvalid))
        else $error("stream activity during clearing pass");

endmodule

// ===== hw/rtl/qvu_mem.sv =====
// ----------------------------------------------------------------------------
// qvu_mem
// Row memory of the Q table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module qvu_mem
    import qvu_pkg::*;
#(
    parameter int DEPTH = NUM_STATES_DEF,
    parameter int AW    = $clog2(NUM_STATES_DEF),
    parameter int WIDTH = NUM_ACTIONS_DEF * Q_W
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr_a,
    input  logic [AW-1:0]    i_rd_addr_b,
    output logic [WIDTH-1:0] o_rd_data_a,
    output logic [WIDTH-1:0] o_rd_data_b,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== hw/rtl/qvu_dp.sv =====
// ----------------------------------------------------------------------------
// qvu_dp
// Update datapath: row maximum, the two multiply stages and the saturating sum.
// ----------------------------------------------------------------------------
module qvu_dp
    import qvu_pkg::*;
#(
    parameter int NUM_ACTIONS = NUM_ACTIONS_DEF,
    parameter int ACW         = $clog2(NUM_ACTIONS_DEF)
) (
    input  logic                                i_clk,
    input  t_dp_ctl                             i_ctl,
    input  t_opcode                             i_op,
    input  logic [ACW-1:0]                      i_act,
    input  logic [REWARD_W-1:0]                 i_reward,
    input  logic [RATE_W-1:0]                   i_learn_rate,
    input  logic [RATE_W-1:0]                   i_discount,
    input  logic [NUM_ACTIONS-1:0][Q_W-1:0]     i_row_cur,
    input  logic [NUM_ACTIONS-1:0][Q_W-1:0]     i_row_nxt,
    output logic [Q_W-1:0]                      o_result,
    output logic [NUM_ACTIONS-1:0][Q_W-1:0]     o_row_new
);

    localparam int NA_P2 = 1 << ACW;

    logic signed [Q_W-1:0]            w_tree [1:2*NA_P2-1];
    logic signed [Q_W-1:0]            r_old;
    logic signed [Q_W-1:0]            r_max;
    logic [RATE_W:0]                  w_keep_w;
    logic signed [Q_W+RATE_W+1:0]     w_p_keep;
    logic signed [Q_W+RATE_W:0]       w_p_fut;
    logic [Q_W-1:0]                   w_fut;
    logic [Q_W:0]                     w_target;
    logic signed [Q_W:0]              r_keep;
    logic signed [Q_W:0]              r_target;
    logic signed [Q_W+RATE_W+1:0]     w_p_gain;
    logic signed [Q_W+1:0]            r_gain;
    logic [Q_W+2:0]                   w_sum;
    logic [Q_W-1:0]                   w_sat;

    always_comb begin
        for (int i = 0; i < NA_P2; i++) begin
            if (i < NUM_ACTIONS) begin
                w_tree[NA_P2+i] = i_row_nxt[ACW'(i)];
            end else begin
                w_tree[NA_P2+i] = Q_MIN;
            end
        end
        for (int i = NA_P2 - 1; i >= 1; i--) begin
            w_tree[i] = (w_tree[2*i] > w_tree[2*i+1]) ? w_tree[2*i] : w_tree[2*i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_rd) begin
            r_old <= i_row_cur[i_act];
            r_max <= w_tree[1];
        end
    end

    assign w_keep_w = ONE_FIX - {1'b0, i_learn_rate};
    assign w_p_keep = r_old * signed'({1'b0, w_keep_w});
    assign w_p_fut  = r_max * signed'({1'b0, i_discount});
    assign w_fut    = w_p_fut[Q_W+FRAC_W-1:FRAC_W];
    assign w_target = {i_reward[REWARD_W-1], i_reward, {FRAC_W{1'b0}}}
                    + {w_fut[Q_W-1], w_fut};

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_mul1) begin
            r_keep   <= w_p_keep[Q_W+RATE_W:FRAC_W];
            r_target <= w_target;
        end
    end

    assign w_p_gain = r_target * signed'({1'b0, i_learn_rate});

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_mul2) begin
            r_gain <= w_p_gain[Q_W+RATE_W+1:FRAC_W];
        end
    end

    assign w_sum = {{2{r_keep[Q_W]}}, r_keep} + {r_gain[Q_W+1], r_gain};

    always_comb begin
        if (!w_sum[Q_W+2] && (|w_sum[Q_W+1:Q_W-1])) begin
            w_sat = Q_MAX;
        end else if (w_sum[Q_W+2] && !(&w_sum[Q_W+1:Q_W-1])) begin
            w_sat = Q_MIN;
        end else begin
            w_sat = w_sum[Q_W-1:0];
        end
    end

    assign o_result = (i_op == OP_READ) ? r_old : w_sat;

    always_comb begin
        o_row_new        = i_row_cur;
        o_row_new[i_act] = o_result;
    end

endmodule

// ===== hw/rtl/qvu_ctrl.sv =====
// ----------------------------------------------------------------------------
// qvu_ctrl
// Sequencer: clearing pass after reset, then one item through read, two
// multiply steps (update items only) and write back.
// ----------------------------------------------------------------------------
module qvu_ctrl
    import qvu_pkg::*;
#(
    parameter int NUM_STATES = NUM_STATES_DEF,
    parameter int AW         = $clog2(NUM_STATES_DEF)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  t_opcode       i_op,
    input  logic          i_out_free,
    output logic          o_in_ready,
    output t_dp_ctl       o_dp_ctl,
    output logic          o_wb_fire,
    output logic          o_mem_we,
    output logic          o_clearing,
    output logic [AW-1:0] o_clr_addr
);

    t_state        r_state;
    t_state        n_state;
    logic [AW-1:0] r_clr_addr;
    logic          w_clr_last;

    assign w_clr_last = (r_clr_addr == AW'(NUM_STATES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (w_clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = (i_op == OP_READ) ? ST_WB : ST_MUL1;
            end
            ST_MUL1: begin
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                n_state = ST_WB;
            end
            ST_WB: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_dp_ctl   = '0;
        o_wb_fire  = 1'b0;
        o_mem_we   = 1'b0;
        o_clearing = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_clearing = 1'b1;
                o_mem_we   = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_RD: begin
                o_dp_ctl.ld_rd = 1'b1;
            end
            ST_MUL1: begin
                o_dp_ctl.ld_mul1 = 1'b1;
            end
            ST_MUL2: begin
                o_dp_ctl.ld_mul2 = 1'b1;
            end
            ST_WB: begin
                o_wb_fire = i_out_free;
                o_mem_we  = i_out_free && (i_op == OP_UPDATE);
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign o_clr_addr = r_clr_addr;

endmodule
